// ----- hw/rtl/gmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_pkg: shared types and constants of the graphical multiple test block
// Fixed sizes, command codes, word structs and controller/datapath links.
// ----------------------------------------------------------------------------
package gmt_pkg;

   localparam int NUM_HYP     = 8;
   localparam int HYP_W       = 3;
   localparam int FRAC_BITS   = 16;
   localparam int VAL_W       = 17;
   localparam int ADDR_W      = 2 * HYP_W;
   localparam int GRAPH_DEPTH = NUM_HYP * NUM_HYP;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int CNT_W       = 4;
   localparam int MASK_W      = 8;
   localparam int DIV_CNT_W   = 4;

   localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [HYP_W-1:0] HYP_LAST = HYP_W'(NUM_HYP - 1);

   // request commands
   localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
   localparam logic [1:0] CMD_LOAD_GRAPH  = 2'd1;
   localparam logic [1:0] CMD_LOAD_PVALUE = 2'd2;
   localparam logic [1:0] CMD_RUN         = 2'd3;

   // work graph write sources
   localparam logic [1:0] WSRC_ZERO = 2'd0;
   localparam logic [1:0] WSRC_COPY = 2'd1;
   localparam logic [1:0] WSRC_DIV  = 2'd2;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [2:0]       row_index;
      logic [2:0]       col_index;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] reject_mask;
      logic [CNT_W-1:0]  reject_count;
      logic              stopped_on_fail;
   } rsp_type;

   typedef struct packed {
      logic              load;
      logic              run_init;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [1:0]        wr_src;
      logic [HYP_W-1:0]  idx;
      logic              sel_step;
      logic              sel_first;
      logic              reject;
      logic              row_cap;
      logic              wupd;
      logic              col_cap;
      logic              den_calc;
      logic              num_calc;
      logic              div_start;
      logic              finish;
      logic              stopped;
   } ctl_cmd_type;

   typedef struct packed {
      logic [NUM_HYP-1:0] active;
      logic [HYP_W-1:0]   sel_idx;
      logic               found;
      logic               pass;
      logic               last;
      logic               div_done;
   } dp_sts_type;

endpackage

// ----- hw/rtl/gmt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_div: saturating fraction divider
// Returns (num << FRAC_BITS) / den clipped at 1.0, zero for a zero
// divisor; restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmt_div import gmt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W:0]   num,
   input  logic [VAL_W-1:0] den,
   output logic             done,
   output logic [VAL_W-1:0] quo
);

   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [VAL_W-1:0]     rem_ff;
   logic [VAL_W-1:0]     den_ff;
   logic [VAL_W-1:0]     res_ff;
   logic [VAL_W:0]       rem2_in;
   logic                 ge_in;
   logic [VAL_W:0]       diff_in;

   // shift in one bit, subtract when it fits
   assign rem2_in = {rem_ff, 1'b0};
   assign ge_in   = rem2_in >= {1'b0, den_ff};
   assign diff_in = rem2_in - {1'b0, den_ff};

   // control: run flag, step count, done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (den == '0 || num >= {1'b0, den}) begin
               done_ff <= 1'b1;
            end else begin
               run_ff <= 1'b1;
               cnt_ff <= DIV_CNT_W'(FRAC_BITS - 1);
            end
         end else if (run_ff) begin
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // datapath: remainder and quotient
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= num[VAL_W-1:0];
         if (den == '0) begin
            res_ff <= '0;
         end else if (num >= {1'b0, den}) begin
            res_ff <= ONE;
         end else begin
            res_ff <= '0;
         end
      end else if (run_ff) begin
         rem_ff <= ge_in ? diff_in[VAL_W-1:0] : rem2_in[VAL_W-1:0];
         res_ff <= {res_ff[VAL_W-2:0], ge_in};
      end
   end

   assign done = done_ff;
   assign quo  = res_ff;

`ifndef NO_ASSERTIONS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");
`endif

endmodule

// ----- hw/rtl/gmt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_dp: graphical test datapath
// Load stores, work graph memory, selection compare, weight update and
// matrix renormalization arithmetic, result register.
// ----------------------------------------------------------------------------
module gmt_dp import gmt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req,
   input  ctl_cmd_type cmd,
   output dp_sts_type  sts,
   output logic        rsp_valid,
   output rsp_type     rsp
);

   logic [VAL_W-1:0]       iw_ff [NUM_HYP];
   logic [VAL_W-1:0]       pv_ff [NUM_HYP];
   logic [VAL_W-1:0]       ww_ff [NUM_HYP];
   logic [VAL_W-1:0]       rowj_ff [NUM_HYP];
   logic [VAL_W-1:0]       ig_mem [GRAPH_DEPTH];
   logic [VAL_W-1:0]       wg_mem [GRAPH_DEPTH];
   logic [GRAPH_DEPTH-1:0] ig_vld_ff;
   logic                   ig_vld_rd_ff;
   logic [VAL_W-1:0]       ig_rd_ff;
   logic [VAL_W-1:0]       wg_rd_ff;
   logic [NUM_HYP-1:0]     active_ff;
   logic [NUM_HYP-1:0]     rejected_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [HYP_W-1:0]       j_ff;
   logic [VAL_W-1:0]       wj_ff;
   logic [VAL_W-1:0]       pj_ff;
   logic                   found_ff;
   logic [VAL_W-1:0]       colj_ff;
   logic [VAL_W-1:0]       den_ff;
   logic [VAL_W:0]         num_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [VAL_W-1:0]  val_in;
   logic [ADDR_W-1:0] ld_addr_in;
   logic [PROD_W-1:0] lhs_in;
   logic [PROD_W-1:0] rhs_in;
   logic              cand_in;
   logic [PROD_W-1:0] prod_w_in;
   logic [VAL_W:0]    wsum_in;
   logic [PROD_W-1:0] prod_rc_in;
   logic [VAL_W-1:0]  wr_data_in;
   logic              div_done;
   logic [VAL_W-1:0]  div_quo;

   // clip load word at 1.0
   assign val_in     = (req.value > ONE) ? ONE : req.value;
   assign ld_addr_in = {req.row_index, req.col_index};

   // hold weights and p-values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HYP; i++) begin
            iw_ff[i] <= '0;
            pv_ff[i] <= '0;
         end
         ig_vld_ff <= '0;
      end else if (cmd.load) begin
         case (req.cmd)
            CMD_LOAD_WEIGHT: iw_ff[req.row_index] <= val_in;
            CMD_LOAD_PVALUE: pv_ff[req.row_index] <= val_in;
            CMD_LOAD_GRAPH:  ig_vld_ff[ld_addr_in] <= 1'b1;
            default: ;
         endcase
      end
   end

   // initial graph memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.load && req.cmd == CMD_LOAD_GRAPH) begin
         ig_mem[ld_addr_in] <= val_in;
      end
      ig_rd_ff     <= ig_mem[cmd.rd_addr];
      ig_vld_rd_ff <= ig_vld_ff[cmd.rd_addr];
   end

   // work graph write source
   always_comb begin
      case (cmd.wr_src)
         WSRC_COPY: wr_data_in = ig_vld_rd_ff ? ig_rd_ff : '0;
         WSRC_DIV:  wr_data_in = div_quo;
         default:   wr_data_in = '0;
      endcase
   end

   // work graph memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         wg_mem[cmd.wr_addr] <= wr_data_in;
      end
      wg_rd_ff <= wg_mem[cmd.rd_addr];
   end

   // cross-multiplied ratio compare against current pick
   assign lhs_in  = PROD_W'(pv_ff[cmd.idx]) * PROD_W'(wj_ff);
   assign rhs_in  = PROD_W'(pj_ff) * PROD_W'(ww_ff[cmd.idx]);
   assign cand_in = active_ff[cmd.idx] && (ww_ff[cmd.idx] != '0) &&
                    (cmd.sel_first || !found_ff || (lhs_in < rhs_in));

   // weight passed along the graph
   assign prod_w_in = PROD_W'(wj_ff) * PROD_W'(rowj_ff[cmd.idx]);
   assign wsum_in   = {1'b0, ww_ff[cmd.idx]} + {1'b0, prod_w_in[FRAC_BITS +: VAL_W]};

   // row j entry times column j entry, shared by numerator and denominator
   assign prod_rc_in = PROD_W'(rowj_ff[cmd.idx]) * PROD_W'(colj_ff);

   // run control state: masks, count, pick, result
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         rejected_ff  <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.run_init) begin
            active_ff   <= '1;
            rejected_ff <= '0;
            count_ff    <= '0;
         end
         if (cmd.sel_step) begin
            found_ff <= cmd.sel_first ? cand_in : (found_ff | cand_in);
         end
         if (cmd.reject) begin
            active_ff[j_ff]   <= 1'b0;
            rejected_ff[j_ff] <= 1'b1;
            count_ff          <= count_ff + 1'b1;
         end
      end
   end

   // work weights
   always_ff @(posedge clock) begin
      if (cmd.run_init) begin
         for (int i = 0; i < NUM_HYP; i++) begin
            ww_ff[i] <= iw_ff[i];
         end
      end else if (cmd.wupd && active_ff[cmd.idx]) begin
         ww_ff[cmd.idx] <= (wsum_in > {1'b0, ONE}) ? ONE : wsum_in[VAL_W-1:0];
      end else if (cmd.reject) begin
         ww_ff[j_ff] <= '0;
      end
   end

   // pick, captured row and column, operands, result word
   always_ff @(posedge clock) begin
      if (cmd.sel_step && cand_in) begin
         j_ff  <= cmd.idx;
         wj_ff <= ww_ff[cmd.idx];
         pj_ff <= pv_ff[cmd.idx];
      end
      if (cmd.row_cap) begin
         rowj_ff[cmd.idx] <= wg_rd_ff;
      end
      if (cmd.col_cap) begin
         colj_ff <= wg_rd_ff;
      end
      if (cmd.den_calc) begin
         den_ff <= ONE - prod_rc_in[FRAC_BITS +: VAL_W];
      end
      if (cmd.num_calc) begin
         num_ff <= {1'b0, wg_rd_ff} + {1'b0, prod_rc_in[FRAC_BITS +: VAL_W]};
      end
      if (cmd.finish) begin
         rsp_ff.reject_mask     <= MASK_W'(rejected_ff);
         rsp_ff.reject_count    <= count_ff;
         rsp_ff.stopped_on_fail <= cmd.stopped;
      end
   end

   gmt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign sts.active   = active_ff;
   assign sts.sel_idx  = j_ff;
   assign sts.found    = found_ff;
   assign sts.pass     = pj_ff <= wj_ff;
   assign sts.last     = (active_ff & ~(NUM_HYP'(1) << j_ff)) == '0;
   assign sts.div_done = div_done;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef NO_ASSERTIONS
   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      (rejected_ff & active_ff) == '0)
      else $error("hypothesis both active and rejected");
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(rejected_ff)))
      else $error("reject count out of step with mask");
`endif

endmodule

// ----- hw/rtl/gmt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_ctrl: graphical test sequencer
// Steps copy, selection, decision, weight pass and matrix sweep, issuing
// datapath commands and reading back status.
// ----------------------------------------------------------------------------
module gmt_ctrl import gmt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_cmd,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd,
   output logic        busy
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_COPY   = 4'd1;
   localparam logic [3:0] S_SEL    = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_ROWJ   = 4'd4;
   localparam logic [3:0] S_WUPD   = 4'd5;
   localparam logic [3:0] S_MHEAD  = 4'd6;
   localparam logic [3:0] S_MCOL   = 4'd7;
   localparam logic [3:0] S_MDEN   = 4'd8;
   localparam logic [3:0] S_MRD    = 4'd9;
   localparam logic [3:0] S_MMUL   = 4'd10;
   localparam logic [3:0] S_MDIV   = 4'd11;
   localparam logic [3:0] S_MWAIT  = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   logic [3:0]       state_ff, state_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic [HYP_W-1:0] l_ff, l_in;
   logic [HYP_W-1:0] k_ff, k_in;
   logic             adv_in;
   logic             live_in;
   logic [6:0]       cnt_m1_in;

   assign live_in   = sts.active[l_ff] && sts.active[k_ff] && (l_ff != k_ff);
   assign cnt_m1_in = cnt_ff - 1'b1;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      l_in     = l_ff;
      k_in     = k_ff;
      adv_in   = 1'b0;
      cmd         = '0;
      cmd.rd_addr = {l_ff, k_ff};
      cmd.wr_addr = {l_ff, k_ff};
      cmd.wr_src  = WSRC_ZERO;
      cmd.idx     = k_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_RUN) begin
                  cmd.run_init = 1'b1;
                  cnt_in       = '0;
                  state_in     = S_COPY;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_COPY: begin
            // read one ahead, write the entry read last cycle
            cmd.rd_addr = cnt_ff[ADDR_W-1:0];
            cmd.wr_addr = cnt_m1_in[ADDR_W-1:0];
            cmd.wr_src  = WSRC_COPY;
            cmd.wr_en   = (cnt_ff != '0);
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == 7'(GRAPH_DEPTH)) begin
               k_in     = '0;
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            cmd.sel_step  = 1'b1;
            cmd.sel_first = (k_ff == '0);
            k_in          = k_ff + 1'b1;
            if (k_ff == HYP_LAST) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!sts.found || !sts.pass) begin
               cmd.finish  = 1'b1;
               cmd.stopped = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.reject = 1'b1;
               cnt_in     = '0;
               state_in   = sts.last ? S_DONE : S_ROWJ;
            end
         end
         S_ROWJ: begin
            // capture row of the rejected hypothesis
            cmd.rd_addr = {sts.sel_idx, cnt_ff[HYP_W-1:0]};
            cmd.idx     = cnt_m1_in[HYP_W-1:0];
            cmd.row_cap = (cnt_ff != '0);
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == 7'(NUM_HYP)) begin
               k_in     = '0;
               state_in = S_WUPD;
            end
         end
         S_WUPD: begin
            cmd.wupd = 1'b1;
            k_in     = k_ff + 1'b1;
            if (k_ff == HYP_LAST) begin
               l_in     = '0;
               state_in = S_MHEAD;
            end
         end
         S_MHEAD: begin
            k_in = '0;
            if (sts.active[l_ff]) begin
               cmd.rd_addr = {l_ff, sts.sel_idx};
               state_in    = S_MCOL;
            end else begin
               state_in = S_MRD;
            end
         end
         S_MCOL: begin
            cmd.col_cap = 1'b1;
            state_in    = S_MDEN;
         end
         S_MDEN: begin
            cmd.den_calc = 1'b1;
            cmd.idx      = l_ff;
            state_in     = S_MRD;
         end
         S_MRD: begin
            if (live_in) begin
               state_in = S_MMUL;
            end else begin
               // clear dropped rows, columns and the diagonal
               cmd.wr_en = 1'b1;
               adv_in    = 1'b1;
            end
         end
         S_MMUL: begin
            cmd.num_calc = 1'b1;
            state_in     = S_MDIV;
         end
         S_MDIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_MWAIT;
         end
         S_MWAIT: begin
            if (sts.div_done) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = WSRC_DIV;
               adv_in     = 1'b1;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // step through the matrix
      if (adv_in) begin
         if (k_ff == HYP_LAST) begin
            k_in = '0;
            if (l_ff == HYP_LAST) begin
               state_in = S_SEL;
            end else begin
               l_in     = l_ff + 1'b1;
               state_in = S_MHEAD;
            end
         end else begin
            k_in     = k_ff + 1'b1;
            state_in = S_MRD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         l_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         l_ff     <= l_in;
         k_ff     <= k_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef NO_ASSERTIONS
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !cmd.wr_en)
      else $error("work graph written while idle");
   a_wait_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MWAIT && sts.div_done) |=>
         (state_ff == S_MRD || state_ff == S_MHEAD || state_ff == S_SEL))
      else $error("matrix sweep did not advance after divide");
`endif

endmodule

// ----- hw/rtl/graphical_multiple_test_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graphical_multiple_test_top: graphical multiple testing engine
// Loads weights, transition matrix and p-values; a run word performs the
// graphical rejection procedure and returns one rejection result word.
// ----------------------------------------------------------------------------
// A load word (weight, matrix entry or p-value) is stored while busy
// stays low. A run word copies the 64-entry matrix into the work memory,
// then each round selects, decides, reads the chosen row and passes its
// weight, followed by the matrix sweep over every row head: dropped rows,
// columns and the diagonal are cleared, and each live entry is recomputed
// through the bit-serial divider, which skips its bit steps when the
// quotient clips at 1.0 or the divisor is zero. The result word is shown
// on rsp_data for exactly one cycle with rsp_valid; the receiver must take
// it then, as the block does not wait.
// ----------------------------------------------------------------------------
module graphical_multiple_test_top import gmt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   gmt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .sts     (sts),
      .cmd     (cmd),
      .busy    (busy)
   );

   gmt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule
